// File: sv/pfl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfl_pkg
// shared types and constants of the page free-list allocator
// ----------------------------------------------------------------------------
package pfl_pkg;

  // fixed field widths
  localparam int PAGE_IDX_W = 12;
  localparam int STEP_W     = 12;
  localparam int STATUS_W   = 2;
  localparam int TDATA_W    = 16;

  // request kinds carried on in_tuser
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // result status codes carried on out_tuser
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_WALK,
    S_RESP
  } pfl_state_t;

endpackage

// File: sv/pfl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfl_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module pfl_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/pfl_walk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfl_walk
// link walker: one shared incrementer and compare chain new pages, one a cycle
// ----------------------------------------------------------------------------
module pfl_walk #(
  parameter int MAX_PAGES = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [$clog2(MAX_PAGES+1)-1:0] start_page,
  input  logic [$clog2(MAX_PAGES+1)-1:0] target,
  output logic                          wr_en,
  output logic [$clog2(MAX_PAGES)-1:0]   wr_addr,
  output logic [$clog2(MAX_PAGES+1)-1:0] wr_data,
  output logic                          last
);

  localparam int PW = $clog2(MAX_PAGES + 1);
  localparam int AW = $clog2(MAX_PAGES);
  localparam logic [PW-1:0] NULL_LINK = PW'(MAX_PAGES);

  logic          busy_r, busy_nxt;
  logic [PW-1:0] page_r, page_nxt;
  logic [PW-1:0] target_r, target_nxt;
  logic [PW-1:0] succ;

  // shared unit: successor and end-of-run compare
  assign succ    = page_r + PW'(1);
  assign last    = busy_r && (succ == target_r);
  assign wr_en   = busy_r;
  assign wr_addr = page_r[AW-1:0];
  assign wr_data = (succ == target_r) ? NULL_LINK : succ;

  always_comb begin
    busy_nxt   = busy_r;
    page_nxt   = page_r;
    target_nxt = target_r;
    if (start) begin
      busy_nxt   = 1'b1;
      page_nxt   = start_page;
      target_nxt = target;
    end else if (busy_r) begin
      page_nxt = succ;
      if (succ == target_r) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    page_r   <= page_nxt;
    target_r <= target_nxt;
  end

endmodule

// File: sv/page_free_list_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_free_list_allocator
// lifo free-list page allocator with on-demand store growth
// ----------------------------------------------------------------------------
// One request beat at a time: an allocate pops the head of a free list that
// is linked through a link ram (one entry per page), a free pushes a page
// back. Page 0 is the header and is never handed out. When the list is empty
// an allocate first grows the store, by growth_step pages or by doubling the
// page count when growth_step is 0, capped at MAX_PAGES; a link walker then
// writes one new link per cycle. After the accepting edge, a free passes
// through S_EXEC and S_RESP, an allocate from the list through S_EXEC,
// S_POP (registered link-ram read) and S_RESP, and an allocate with growth
// through S_EXEC, S_WALK (one link per added page, one ram write port) and
// S_RESP, before the result beat is loaded. in_tready is low from acceptance
// until the result is loaded into the output register and high again once it
// is, so a request is taken only after the last is through; a result that
// waits on out_tready holds the block for as long. The link ram is not
// cleared at reset; only written entries are ever read.
// ----------------------------------------------------------------------------
module page_free_list_allocator
  import pfl_pkg::*;
#(
  parameter int MAX_PAGES = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // [11:0] free_page, rest zero
  input  logic               in_tuser,   // [0] mode
  // result channel
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // [11:0] page_index, rest zero
  output logic [STATUS_W-1:0] out_tuser, // [1:0] status
  // configuration
  input  logic               cfg_wr_en,
  input  logic [STEP_W-1:0]  cfg_wr_data // growth_step
);

  // page numbers need one code beyond the last page for the null link
  localparam int PW = $clog2(MAX_PAGES + 1);
  localparam int AW = $clog2(MAX_PAGES);
  // width wide enough for page_count against a 12-bit page index
  localparam int CW = (PW > PAGE_IDX_W) ? PW : PAGE_IDX_W;
  // growth sum: doubled count or count plus step, before the cap
  localparam int TW = CW + 1;
  localparam logic [PW-1:0] NULL_LINK = PW'(MAX_PAGES);

  pfl_state_t state_r, state_nxt;

  logic [STEP_W-1:0]     growth_r;
  logic [PW-1:0]         head_r, head_nxt;
  logic [PW-1:0]         count_r, count_nxt;
  logic                  req_mode_r, req_mode_nxt;
  logic [PAGE_IDX_W-1:0] req_page_r, req_page_nxt;
  logic [PAGE_IDX_W-1:0] res_page_r, res_page_nxt;
  logic [STATUS_W-1:0]   res_status_r, res_status_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [PAGE_IDX_W-1:0] out_page_r, out_page_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;

  // link ram ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [PW-1:0] ram_wdata;
  logic [PW-1:0] ram_rdata;

  // free-path write (from the sequencer)
  logic          free_we;

  // walker
  logic          walk_start;
  logic          walk_we;
  logic [AW-1:0] walk_waddr;
  logic [PW-1:0] walk_wdata;
  logic          walk_last;

  // growth target
  logic [TW-1:0] grow_sum;
  logic [PW-1:0] grow_target;
  logic [PW-1:0] count_succ;
  logic          free_bad;

  assign grow_sum = (growth_r == '0) ? (TW'(count_r) << 1)
                                      : (TW'(count_r) + TW'(growth_r));
  assign grow_target = (grow_sum > TW'(MAX_PAGES)) ? NULL_LINK : PW'(grow_sum);
  assign count_succ  = count_r + PW'(1);

  // header page or a page beyond the store
  assign free_bad = (req_page_r == '0) || (CW'(req_page_r) >= CW'(count_r));

  // link ram: the walker owns the write port while growing
  assign ram_we    = walk_we | free_we;
  assign ram_waddr = walk_we ? walk_waddr : AW'(req_page_r);
  assign ram_wdata = walk_we ? walk_wdata : head_r;

  pfl_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_PAGES)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (head_r[AW-1:0]),  // head link always in flight
    .rd_data (ram_rdata)
  );

  pfl_walk #(
    .MAX_PAGES (MAX_PAGES)
  ) u_walk (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (walk_start),
    .start_page (count_r),
    .target     (grow_target),
    .wr_en      (walk_we),
    .wr_addr    (walk_waddr),
    .wr_data    (walk_wdata),
    .last       (walk_last)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'(out_page_r);
  assign out_tuser  = out_status_r;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    req_mode_nxt   = req_mode_r;
    req_page_nxt   = req_page_r;
    res_page_nxt   = res_page_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_page_nxt   = out_page_r;
    out_status_nxt = out_status_r;
    free_we        = 1'b0;
    walk_start     = 1'b0;

    // output register drains independently of the sequencer
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          req_mode_nxt = in_tuser;
          req_page_nxt = in_tdata[PAGE_IDX_W-1:0];
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        res_page_nxt   = '0;
        res_status_nxt = ST_OK;
        if (req_mode_r == MODE_FREE) begin
          if (free_bad) begin
            res_status_nxt = ST_BAD_FREE;
          end else begin
            // push: link to old head, page becomes head
            free_we  = 1'b1;
            head_nxt = PW'(req_page_r);
          end
          state_nxt = S_RESP;
        end else if (head_r != NULL_LINK) begin
          // head link read is under way, taken in the next cycle
          state_nxt = S_POP;
        end else if (count_r >= NULL_LINK) begin
          res_status_nxt = ST_FULL;
          state_nxt      = S_RESP;
        end else begin
          // grow, then pop the first new page straight away
          walk_start   = 1'b1;
          res_page_nxt = PAGE_IDX_W'(count_r);
          head_nxt     = (count_succ == grow_target) ? NULL_LINK : count_succ;
          count_nxt    = grow_target;
          state_nxt    = S_WALK;
        end
      end
      S_POP: begin
        res_page_nxt = PAGE_IDX_W'(head_r);
        head_nxt     = ram_rdata;
        state_nxt    = S_RESP;
      end
      S_WALK: begin
        if (walk_last) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_page_nxt   = res_page_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= NULL_LINK;
      count_r     <= PW'(1);
      growth_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        growth_r <= cfg_wr_data;
      end
    end
    req_mode_r   <= req_mode_nxt;
    req_page_r   <= req_page_nxt;
    res_page_r   <= res_page_nxt;
    res_status_r <= res_status_nxt;
    out_page_r   <= out_page_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule
